// ===== design/ecgr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecgr_pkg
// Shared constants for the ECG R-peak detector: coefficients, timing windows,
// register indexes and serial arithmetic unit sizes.
// ----------------------------------------------------------------------------
package ecgr_pkg;

    // Fraction bits of the filtered signal path
    localparam int FRAC = 7;

    // Serial multiplier: coefficient operand width (Q16 values below 2^17)
    localparam int COEF_W = 17;

    // Serial divider: dividend and divisor widths
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 33;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEC_LENGTH = 2'd1;
    localparam logic [7:0] DEC_LEN_RESET = 8'd8;

    // Exponential average coefficients, Q16 (normal / small animal)
    localparam logic [COEF_W-1:0] K_BASE_N  = 17'd655;
    localparam logic [COEF_W-1:0] K_BASE_S  = 17'd1311;
    localparam logic [COEF_W-1:0] K_SHORT_N = 17'd13107;
    localparam logic [COEF_W-1:0] K_SHORT_S = 17'd19661;
    localparam logic [COEF_W-1:0] K_LONG_N  = 17'd6554;
    localparam logic [COEF_W-1:0] K_LONG_S  = 17'd9830;
    localparam logic [COEF_W-1:0] K_SLOPE_N = 17'd6554;
    localparam logic [COEF_W-1:0] K_SLOPE_S = 17'd13107;
    localparam logic [COEF_W-1:0] K_DECAY_N = 17'd65484;
    localparam logic [COEF_W-1:0] K_DECAY_S = 17'd65339;

    // Threshold factor, Q16
    localparam logic [20:0]       FIT_BASE  = 21'd39322;
    localparam logic [COEF_W-1:0] FIT_CAP_N = 17'd85197;
    localparam logic [COEF_W-1:0] FIT_CAP_S = 17'd65536;
    localparam logic [COEF_W-1:0] FIT_NEAR  = 17'd66191;
    localparam logic [COEF_W-1:0] Q16_ONE   = 17'd65536;

    // Timing, in ms or samples
    localparam logic [31:0] WIN_N      = 32'd100;
    localparam logic [31:0] WIN_S      = 32'd30;
    localparam logic [31:0] PAIR_N     = 32'd40;
    localparam logic [31:0] PAIR_S     = 32'd20;
    localparam logic [31:0] REFR_N     = 32'd150;
    localparam logic [31:0] REFR_S     = 32'd60;
    localparam logic [31:0] BEAT_DELAY = 32'd30;
    localparam logic [31:0] RR_MAX     = 32'd2000;

endpackage

// ===== design/ecgr_mul.sv =====
// ----------------------------------------------------------------------------
// ecgr_mul
// Bit-serial signed-by-unsigned multiplier, one coefficient bit per cycle,
// MSB first. done pulses when the last step is registered.
// ----------------------------------------------------------------------------
module ecgr_mul #(
    parameter int AW = 35
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [AW-1:0]                  a,
    input  logic [ecgr_pkg::COEF_W-1:0]           b,
    output logic                                  done,
    output logic signed [AW+ecgr_pkg::COEF_W-1:0] p
);

    localparam int PW = AW + ecgr_pkg::COEF_W;
    localparam int CW = $clog2(ecgr_pkg::COEF_W + 1);

    logic signed [AW-1:0]            a_reg;
    logic [ecgr_pkg::COEF_W-1:0]     b_reg;
    logic signed [PW-1:0]            acc_reg;
    logic [CW-1:0]                   cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic signed [PW-1:0]            a_ext;
    logic signed [PW-1:0]            acc_next;

    // shift-and-add step
    assign a_ext    = {{ecgr_pkg::COEF_W{a_reg[AW-1]}}, a_reg};
    assign acc_next = {acc_reg[PW-2:0], 1'b0} + (b_reg[ecgr_pkg::COEF_W-1] ? a_ext : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            a_reg    <= a;
            b_reg    <= b;
            acc_reg  <= '0;
            cnt_reg  <= CW'(ecgr_pkg::COEF_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[ecgr_pkg::COEF_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ===== design/ecgr_div.sv =====
// ----------------------------------------------------------------------------
// ecgr_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// done pulses when the last step is registered; quot holds until next start.
// ----------------------------------------------------------------------------
module ecgr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ecgr_pkg::DIV_NW-1:0]   num,
    input  logic [ecgr_pkg::DIV_DW-1:0]   den,
    output logic                          done,
    output logic [ecgr_pkg::DIV_NW-1:0]   quot
);

    localparam int NW = ecgr_pkg::DIV_NW;
    localparam int DW = ecgr_pkg::DIV_DW;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] nq_reg;      // dividend bits out at top, quotient bits in at bottom
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic          q_bit;
    logic [DW:0]   rem_next;

    // trial subtract
    assign rem_sh   = {rem_reg[DW-1:0], nq_reg[NW-1]};
    assign q_bit    = rem_sh >= {1'b0, den_reg};
    assign rem_next = q_bit ? rem_sh - {1'b0, den_reg} : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nq_reg   <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            nq_reg   <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            cnt_reg  <= CW'(NW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            nq_reg  <= {nq_reg[NW-2:0], q_bit};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = nq_reg;

endmodule

// ===== design/ecg_r_peak_detector.sv =====
// ----------------------------------------------------------------------------
// ecg_r_peak_detector
// R-peak detector with RR interval output and decimated signal output.
//
//   channel | handshake             | word
//   --------+-----------------------+----------------------------------------
//   in      | in_valid / in_stall   | sample, time_ms
//   out     | out_valid / out_stall | r_peak, rr_valid, rr_interval,
//           |                       | beat_accepted, dec_valid, dec_value
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word at a time. Ten products on a bit-serial multiplier (start, 17 steps,
// done) and one or two quotients on a radix-2 divider (start, 48 steps, done)
// set the time from the accepting edge to the result register; the second
// quotient is taken only when a decimated value completes.
// The output register lets the next word be processed while a result waits.
// Async active-low reset clears all filter state; dec_length resets to 8.
// ----------------------------------------------------------------------------
module ecg_r_peak_detector #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int AGE_WIDTH    = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample,
    input  logic [31:0]                           time_ms,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  r_peak,
    output logic                                  rr_valid,
    output logic [10:0]                           rr_interval,
    output logic                                  beat_accepted,
    output logic                                  dec_valid,
    output logic signed [SAMPLE_WIDTH-1:0]        dec_value,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ecgr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [7:0]                            cfg_data
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = SW + ecgr_pkg::FRAC + 4;
    localparam int PW   = AW + ecgr_pkg::COEF_W;
    localparam int SUMW = SW + 8;
    localparam int KW   = ecgr_pkg::COEF_W;
    localparam logic [AGE_WIDTH-1:0] AGE_TOP = {AGE_WIDTH{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE, S_BASE, S_BASE_W, S_SHORT, S_SHORT_W, S_LONG, S_LONG_W,
        S_RAVG, S_RAVG_W, S_FAVG, S_FAVG_W, S_RPK, S_RPK_W, S_FPK, S_FPK_W,
        S_FDIV, S_FDIV_W, S_ESQ, S_ESQ_W, S_RCMP, S_RCMP_W, S_FCMP, S_FCMP_W,
        S_BEAT, S_DDIV, S_DDIV_W, S_FINISH
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic       small_reg, small_next;
    logic [7:0] dec_length_reg, dec_length_next;

    // current word
    logic signed [SW-1:0] x_reg, x_next;
    logic [31:0]          now_reg, now_next;

    // filter and detector state
    logic signed [AW-1:0] baseline_reg, baseline_next;
    logic signed [AW-1:0] avg_short_reg, avg_short_next;
    logic signed [AW-1:0] avg_long_reg, avg_long_next;
    logic signed [AW-1:0] rise_avg_reg, rise_avg_next;
    logic signed [AW-1:0] fall_avg_reg, fall_avg_next;
    logic signed [AW-1:0] rise_peak_reg, rise_peak_next;
    logic signed [AW-1:0] fall_peak_reg, fall_peak_next;
    logic signed [AW-1:0] rise_level_reg, rise_level_next;
    logic signed [AW-1:0] fall_level_reg, fall_level_next;
    logic signed [SW-1:0] rise_raw_reg, rise_raw_next;
    logic signed [SW-1:0] fall_raw_reg, fall_raw_next;
    logic [AGE_WIDTH-1:0] rise_age_reg, rise_age_next;
    logic [AGE_WIDTH-1:0] fall_age_reg, fall_age_next;
    logic [AGE_WIDTH-1:0] since_beat_reg, since_beat_next;
    logic [31:0]          rise_trig_reg, rise_trig_next;
    logic [31:0]          fall_trig_reg, fall_trig_next;
    logic [31:0]          beat_ms_reg, beat_ms_next;
    logic [31:0]          prior_beat_reg, prior_beat_next;
    logic [7:0]           dec_count_reg, dec_count_next;
    logic signed [SUMW-1:0] dec_sum_reg, dec_sum_next;

    // threshold factor scratch
    logic          far_reg, far_next;
    logic [KW-1:0] eabs_reg, eabs_next;
    logic [KW-1:0] fit_reg, fit_next;

    // result being built
    logic                 res_rdet_reg, res_rdet_next;
    logic                 res_rr_ok_reg, res_rr_ok_next;
    logic [10:0]          res_rr_reg, res_rr_next;
    logic                 res_acc_reg, res_acc_next;
    logic                 res_dok_reg, res_dok_next;
    logic signed [SW-1:0] res_dval_reg, res_dval_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_rdet_reg, out_rdet_next;
    logic                 out_rr_ok_reg, out_rr_ok_next;
    logic [10:0]          out_rr_reg, out_rr_next;
    logic                 out_acc_reg, out_acc_next;
    logic                 out_dok_reg, out_dok_next;
    logic signed [SW-1:0] out_dval_reg, out_dval_next;

    // arithmetic units
    logic                        mul_start;
    logic signed [AW-1:0]        mul_a;
    logic [KW-1:0]               mul_b;
    logic                        mul_done;
    logic signed [PW-1:0]        mul_p;
    logic                        div_start;
    logic [ecgr_pkg::DIV_NW-1:0] div_num;
    logic [ecgr_pkg::DIV_DW-1:0] div_den;
    logic                        div_done;
    logic [ecgr_pkg::DIV_NW-1:0] div_quot;

    // datapath helpers
    logic signed [AW-1:0]   xq, v, dv, rise_tgt, fall_tgt, mul_rnd;
    logic signed [PW-1:0]   rnd_full, rise_sh, fall_sh;
    logic [31:0]            dt, prev_rr, win, pair, refr;
    logic [ecgr_pkg::DIV_DW-1:0] den;
    logic                   far_now;
    logic [KW-1:0]          k_base, k_short, k_long, k_slope, k_decay, fit_cap;
    logic [KW-1:0]          fit_r, fit_f, f_q;
    logic [32:0]            sq;
    logic [35:0]            ten_sq;
    logic [20:0]            dd;
    logic [7:0]             len, cnt_inc;
    logic [SUMW-1:0]        sum_abs;
    logic signed [SUMW-1:0] dq, dval;
    logic signed [SUMW-1:0] sum_inc;

    function automatic logic [AGE_WIDTH-1:0] sat_inc(input logic [AGE_WIDTH-1:0] a);
        return (a == AGE_TOP) ? a : a + 1'b1;
    endfunction

    // rise and fall levels within a factor of three of each other
    function automatic logic levels_close(input logic [AW-1:0] r, input logic [AW-1:0] f);
        logic [AW+1:0] r3;
        logic [AW+1:0] f3;
        r3 = {2'b00, r} + {1'b0, r, 1'b0};
        f3 = {2'b00, f} + {1'b0, f, 1'b0};
        return (r3 > {2'b00, f}) && ({2'b00, r} < f3);
    endfunction

    ecgr_mul #(.AW(AW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    ecgr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // mode-dependent constants
    always_comb
    begin
        k_base  = small_reg ? ecgr_pkg::K_BASE_S  : ecgr_pkg::K_BASE_N;
        k_short = small_reg ? ecgr_pkg::K_SHORT_S : ecgr_pkg::K_SHORT_N;
        k_long  = small_reg ? ecgr_pkg::K_LONG_S  : ecgr_pkg::K_LONG_N;
        k_slope = small_reg ? ecgr_pkg::K_SLOPE_S : ecgr_pkg::K_SLOPE_N;
        k_decay = small_reg ? ecgr_pkg::K_DECAY_S : ecgr_pkg::K_DECAY_N;
        fit_cap = small_reg ? ecgr_pkg::FIT_CAP_S : ecgr_pkg::FIT_CAP_N;
        win     = small_reg ? ecgr_pkg::WIN_S     : ecgr_pkg::WIN_N;
        pair    = small_reg ? ecgr_pkg::PAIR_S    : ecgr_pkg::PAIR_N;
        refr    = small_reg ? ecgr_pkg::REFR_S    : ecgr_pkg::REFR_N;
    end

    // signal path
    assign xq       = {{(AW-SW-ecgr_pkg::FRAC){x_reg[SW-1]}}, x_reg, {ecgr_pkg::FRAC{1'b0}}};
    assign v        = xq - baseline_reg;
    assign dv       = avg_short_reg - avg_long_reg;
    assign rise_tgt = dv[AW-1] ? '0 : dv;
    assign fall_tgt = dv[AW-1] ? -dv : '0;
    assign rnd_full = (mul_p + PW'(32768)) >>> 16;
    assign mul_rnd  = rnd_full[AW-1:0];
    assign rise_sh  = {rise_avg_reg[AW-1], rise_avg_reg, 16'h0000};
    assign fall_sh  = {fall_avg_reg[AW-1], fall_avg_reg, 16'h0000};

    // RR timing
    assign dt      = now_reg - beat_ms_reg;
    assign prev_rr = beat_ms_reg - prior_beat_reg;
    assign den     = {1'b0, prev_rr} + 33'd1;
    assign far_now = {2'b00, dt} >= {den, 1'b0};
    assign f_q     = div_quot[KW-1:0];
    assign fit_r   = ((now_reg - rise_trig_reg) < win) ? ecgr_pkg::FIT_NEAR : fit_reg;
    assign fit_f   = ((now_reg - fall_trig_reg) < win) ? ecgr_pkg::FIT_NEAR : fit_reg;
    assign sq      = mul_p[32:0];
    assign ten_sq  = {sq, 3'b000} + {2'b00, sq, 1'b0};
    assign dd      = 21'((ten_sq + 36'd32768) >> 16) + ecgr_pkg::FIT_BASE;

    // decimation
    assign len     = (dec_length_reg == 8'd0) ? 8'd1 : dec_length_reg;
    assign cnt_inc = dec_count_reg + 8'd1;
    assign sum_inc = dec_sum_reg + {{(SUMW-SW){x_reg[SW-1]}}, x_reg};
    assign sum_abs = dec_sum_reg[SUMW-1] ? SUMW'(-dec_sum_reg) : dec_sum_reg;
    assign dq      = dec_sum_reg[SUMW-1] ? -$signed(div_quot[SUMW-1:0])
                                         : $signed(div_quot[SUMW-1:0]);

    always_comb
    begin
        dval = dq;
        if (32'(fall_age_reg) <= 32'(len))
        begin
            dval = {{(SUMW-SW){fall_raw_reg[SW-1]}}, fall_raw_reg};
        end
        if (32'(rise_age_reg) <= 32'(len))
        begin
            dval = {{(SUMW-SW){rise_raw_reg[SW-1]}}, rise_raw_reg};
        end
    end

    // operand selection for the shared units
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_BASE:
            begin
                mul_start = 1'b1;
                mul_a     = xq - baseline_reg;
                mul_b     = k_base;
            end
            S_SHORT:
            begin
                mul_start = 1'b1;
                mul_a     = v - avg_short_reg;
                mul_b     = k_short;
            end
            S_LONG:
            begin
                mul_start = 1'b1;
                mul_a     = v - avg_long_reg;
                mul_b     = k_long;
            end
            S_RAVG:
            begin
                mul_start = 1'b1;
                mul_a     = rise_tgt - rise_avg_reg;
                mul_b     = k_slope;
            end
            S_FAVG:
            begin
                mul_start = 1'b1;
                mul_a     = fall_tgt - fall_avg_reg;
                mul_b     = k_slope;
            end
            S_RPK:
            begin
                mul_start = 1'b1;
                mul_a     = rise_peak_reg;
                mul_b     = k_decay;
            end
            S_FPK:
            begin
                mul_start = 1'b1;
                mul_a     = fall_peak_reg;
                mul_b     = k_decay;
            end
            S_FDIV:
            begin
                div_start = 1'b1;
                div_num   = {dt, 16'h0000};
                div_den   = den;
            end
            S_ESQ:
            begin
                mul_start = 1'b1;
                mul_a     = {{(AW-KW){1'b0}}, eabs_reg};
                mul_b     = eabs_reg;
            end
            S_RCMP:
            begin
                mul_start = 1'b1;
                mul_a     = rise_peak_reg;
                mul_b     = fit_r;
            end
            S_FCMP:
            begin
                mul_start = 1'b1;
                mul_a     = fall_peak_reg;
                mul_b     = fit_f;
            end
            S_DDIV:
            begin
                div_start = 1'b1;
                div_num   = ecgr_pkg::DIV_NW'(sum_abs);
                div_den   = {25'd0, len};
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // sequencer and state update
    always_comb
    begin
        state_next      = state_reg;
        small_next      = small_reg;
        dec_length_next = dec_length_reg;
        x_next          = x_reg;
        now_next        = now_reg;
        baseline_next   = baseline_reg;
        avg_short_next  = avg_short_reg;
        avg_long_next   = avg_long_reg;
        rise_avg_next   = rise_avg_reg;
        fall_avg_next   = fall_avg_reg;
        rise_peak_next  = rise_peak_reg;
        fall_peak_next  = fall_peak_reg;
        rise_level_next = rise_level_reg;
        fall_level_next = fall_level_reg;
        rise_raw_next   = rise_raw_reg;
        fall_raw_next   = fall_raw_reg;
        rise_age_next   = rise_age_reg;
        fall_age_next   = fall_age_reg;
        since_beat_next = since_beat_reg;
        rise_trig_next  = rise_trig_reg;
        fall_trig_next  = fall_trig_reg;
        beat_ms_next    = beat_ms_reg;
        prior_beat_next = prior_beat_reg;
        dec_count_next  = dec_count_reg;
        dec_sum_next    = dec_sum_reg;
        far_next        = far_reg;
        eabs_next       = eabs_reg;
        fit_next        = fit_reg;
        res_rdet_next   = res_rdet_reg;
        res_rr_ok_next  = res_rr_ok_reg;
        res_rr_next     = res_rr_reg;
        res_acc_next    = res_acc_reg;
        res_dok_next    = res_dok_reg;
        res_dval_next   = res_dval_reg;
        out_valid_next  = out_valid_reg;
        out_rdet_next   = out_rdet_reg;
        out_rr_ok_next  = out_rr_ok_reg;
        out_rr_next     = out_rr_reg;
        out_acc_next    = out_acc_reg;
        out_dok_next    = out_dok_reg;
        out_dval_next   = out_dval_reg;

        // downstream takes the result word
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // register writes, taken only while idle
        if (cfg_valid && state_reg == S_IDLE)
        begin
            case (cfg_index)
                ecgr_pkg::CFG_SMALL_MODE: small_next      = cfg_data[0];
                ecgr_pkg::CFG_DEC_LENGTH: dec_length_next = cfg_data;
                default:                  small_next      = small_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next         = sample;
                    now_next       = time_ms;
                    res_rdet_next  = 1'b0;
                    res_rr_ok_next = 1'b0;
                    res_rr_next    = '0;
                    res_acc_next   = 1'b0;
                    res_dok_next   = 1'b0;
                    res_dval_next  = '0;
                    state_next     = S_BASE;
                end
            end
            S_BASE:  state_next = S_BASE_W;
            S_BASE_W:
            begin
                if (mul_done)
                begin
                    baseline_next = baseline_reg + mul_rnd;
                    state_next    = S_SHORT;
                end
            end
            S_SHORT: state_next = S_SHORT_W;
            S_SHORT_W:
            begin
                if (mul_done)
                begin
                    avg_short_next = avg_short_reg + mul_rnd;
                    state_next     = S_LONG;
                end
            end
            S_LONG:  state_next = S_LONG_W;
            S_LONG_W:
            begin
                if (mul_done)
                begin
                    avg_long_next = avg_long_reg + mul_rnd;
                    state_next    = S_RAVG;
                end
            end
            S_RAVG:  state_next = S_RAVG_W;
            S_RAVG_W:
            begin
                if (mul_done)
                begin
                    rise_avg_next = rise_avg_reg + mul_rnd;
                    state_next    = S_FAVG;
                end
            end
            S_FAVG:  state_next = S_FAVG_W;
            S_FAVG_W:
            begin
                if (mul_done)
                begin
                    fall_avg_next = fall_avg_reg + mul_rnd;
                    state_next    = S_RPK;
                end
            end
            S_RPK:   state_next = S_RPK_W;
            S_RPK_W:
            begin
                if (mul_done)
                begin
                    rise_peak_next = mul_rnd;
                    state_next     = S_FPK;
                end
            end
            S_FPK:   state_next = S_FPK_W;
            S_FPK_W:
            begin
                if (mul_done)
                begin
                    fall_peak_next = mul_rnd;
                    state_next     = S_FDIV;
                end
            end
            S_FDIV:
            begin
                far_next   = far_now;
                state_next = S_FDIV_W;
            end
            S_FDIV_W:
            begin
                if (div_done)
                begin
                    // distance of the RR fraction from one
                    eabs_next  = (f_q >= ecgr_pkg::Q16_ONE) ? f_q - ecgr_pkg::Q16_ONE
                                                            : ecgr_pkg::Q16_ONE - f_q;
                    state_next = S_ESQ;
                end
            end
            S_ESQ:   state_next = S_ESQ_W;
            S_ESQ_W:
            begin
                if (mul_done)
                begin
                    if (far_reg || dd > {4'd0, fit_cap})
                    begin
                        fit_next = fit_cap;
                    end
                    else
                    begin
                        fit_next = dd[KW-1:0];
                    end
                    state_next = S_RCMP;
                end
            end
            S_RCMP:  state_next = S_RCMP_W;
            S_RCMP_W:
            begin
                if (mul_done)
                begin
                    if (rise_sh > mul_p)
                    begin
                        rise_trig_next  = now_reg;
                        rise_age_next   = '0;
                        rise_peak_next  = rise_avg_reg;
                        rise_level_next = rise_avg_reg;
                        rise_raw_next   = x_reg;
                        if (32'(fall_age_reg) < pair &&
                            levels_close(rise_avg_reg, fall_level_reg))
                        begin
                            res_rdet_next   = 1'b1;
                            since_beat_next = '0;
                        end
                    end
                    state_next = S_FCMP;
                end
            end
            S_FCMP:  state_next = S_FCMP_W;
            S_FCMP_W:
            begin
                if (mul_done)
                begin
                    if (fall_sh > mul_p)
                    begin
                        fall_trig_next  = now_reg;
                        fall_age_next   = '0;
                        fall_peak_next  = fall_avg_reg;
                        fall_level_next = fall_avg_reg;
                        fall_raw_next   = x_reg;
                        if (32'(rise_age_reg) < pair &&
                            levels_close(rise_level_reg, fall_avg_reg))
                        begin
                            res_rdet_next   = 1'b1;
                            since_beat_next = '0;
                        end
                    end
                    state_next = S_BEAT;
                end
            end
            S_BEAT:
            begin
                // beat acceptance a fixed number of samples after detection
                if (32'(since_beat_reg) == ecgr_pkg::BEAT_DELAY && dt > refr)
                begin
                    prior_beat_next = beat_ms_reg;
                    beat_ms_next    = now_reg;
                    res_acc_next    = 1'b1;
                    if (dt < ecgr_pkg::RR_MAX)
                    begin
                        res_rr_ok_next = 1'b1;
                        res_rr_next    = dt[10:0];
                    end
                end
                rise_age_next   = sat_inc(rise_age_reg);
                fall_age_next   = sat_inc(fall_age_reg);
                since_beat_next = sat_inc(since_beat_reg);
                dec_count_next  = cnt_inc;
                dec_sum_next    = sum_inc;
                state_next      = (cnt_inc >= len) ? S_DDIV : S_FINISH;
            end
            S_DDIV:  state_next = S_DDIV_W;
            S_DDIV_W:
            begin
                if (div_done)
                begin
                    res_dok_next   = 1'b1;
                    res_dval_next  = dval[SW-1:0];
                    dec_count_next = '0;
                    dec_sum_next   = '0;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_rdet_next  = res_rdet_reg;
                    out_rr_ok_next = res_rr_ok_reg;
                    out_rr_next    = res_rr_reg;
                    out_acc_next   = res_acc_reg;
                    out_dok_next   = res_dok_reg;
                    out_dval_next  = res_dval_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            small_reg      <= 1'b0;
            dec_length_reg <= ecgr_pkg::DEC_LEN_RESET;
            x_reg          <= '0;
            now_reg        <= '0;
            baseline_reg   <= '0;
            avg_short_reg  <= '0;
            avg_long_reg   <= '0;
            rise_avg_reg   <= '0;
            fall_avg_reg   <= '0;
            rise_peak_reg  <= '0;
            fall_peak_reg  <= '0;
            rise_level_reg <= '0;
            fall_level_reg <= '0;
            rise_raw_reg   <= '0;
            fall_raw_reg   <= '0;
            rise_age_reg   <= '0;
            fall_age_reg   <= '0;
            since_beat_reg <= '0;
            rise_trig_reg  <= '0;
            fall_trig_reg  <= '0;
            beat_ms_reg    <= '0;
            prior_beat_reg <= '0;
            dec_count_reg  <= '0;
            dec_sum_reg    <= '0;
            far_reg        <= 1'b0;
            eabs_reg       <= '0;
            fit_reg        <= '0;
            res_rdet_reg   <= 1'b0;
            res_rr_ok_reg  <= 1'b0;
            res_rr_reg     <= '0;
            res_acc_reg    <= 1'b0;
            res_dok_reg    <= 1'b0;
            res_dval_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_rdet_reg   <= 1'b0;
            out_rr_ok_reg  <= 1'b0;
            out_rr_reg     <= '0;
            out_acc_reg    <= 1'b0;
            out_dok_reg    <= 1'b0;
            out_dval_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            small_reg      <= small_next;
            dec_length_reg <= dec_length_next;
            x_reg          <= x_next;
            now_reg        <= now_next;
            baseline_reg   <= baseline_next;
            avg_short_reg  <= avg_short_next;
            avg_long_reg   <= avg_long_next;
            rise_avg_reg   <= rise_avg_next;
            fall_avg_reg   <= fall_avg_next;
            rise_peak_reg  <= rise_peak_next;
            fall_peak_reg  <= fall_peak_next;
            rise_level_reg <= rise_level_next;
            fall_level_reg <= fall_level_next;
            rise_raw_reg   <= rise_raw_next;
            fall_raw_reg   <= fall_raw_next;
            rise_age_reg   <= rise_age_next;
            fall_age_reg   <= fall_age_next;
            since_beat_reg <= since_beat_next;
            rise_trig_reg  <= rise_trig_next;
            fall_trig_reg  <= fall_trig_next;
            beat_ms_reg    <= beat_ms_next;
            prior_beat_reg <= prior_beat_next;
            dec_count_reg  <= dec_count_next;
            dec_sum_reg    <= dec_sum_next;
            far_reg        <= far_next;
            eabs_reg       <= eabs_next;
            fit_reg        <= fit_next;
            res_rdet_reg   <= res_rdet_next;
            res_rr_ok_reg  <= res_rr_ok_next;
            res_rr_reg     <= res_rr_next;
            res_acc_reg    <= res_acc_next;
            res_dok_reg    <= res_dok_next;
            res_dval_reg   <= res_dval_next;
            out_valid_reg  <= out_valid_next;
            out_rdet_reg   <= out_rdet_next;
            out_rr_ok_reg  <= out_rr_ok_next;
            out_rr_reg     <= out_rr_next;
            out_acc_reg    <= out_acc_next;
            out_dok_reg    <= out_dok_next;
            out_dval_reg   <= out_dval_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign r_peak        = out_rdet_reg;
    assign rr_valid      = out_rr_ok_reg;
    assign rr_interval   = out_rr_reg;
    assign beat_accepted = out_acc_reg;
    assign dec_valid     = out_dok_reg;
    assign dec_value     = out_dval_reg;

endmodule

// ===== sim/tb_ecg_r_peak_detector.sv =====
// ----------------------------------------------------------------------------
// tb_ecg_r_peak_detector
// Self-checking bench for the ECG R-peak detector. Samples go in through the
// valid/stall input channel. Each accepted word is run through a bit-accurate
// software copy of the filter, threshold and decimation chain. Every output
// word is compared field by field with the oldest expected word. The run
// covers a directed table, then synthetic heartbeat trains with random
// content and noise, under several register settings with random idling on
// both sides.
// ----------------------------------------------------------------------------
module tb_ecg_r_peak_detector;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = 24;
    localparam int AW = 16;
    localparam longint AGE_TOP = (64'd1 << AW) - 1;
    localparam logic [ecgr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam longint CYCLE_LIMIT = 5000000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic                 r_det;
        logic                 rr_ok;
        logic [10:0]          rr_ms;
        logic                 accepted;
        logic                 d_ok;
        logic signed [SW-1:0] d_val;
    } beat_word_t;

    typedef struct {
        logic signed [SW-1:0] smp;
        logic [31:0]          t;
        bit                   typed;
        beat_word_t           want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [SW-1:0] sample;
    logic [31:0]          time_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic                 r_peak;
    logic                 rr_valid;
    logic [10:0]          rr_interval;
    logic                 beat_accepted;
    logic                 dec_valid;
    logic signed [SW-1:0] dec_value;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ecgr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    ecg_r_peak_detector #(
        .SAMPLE_WIDTH(SW),
        .AGE_WIDTH   (AW)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .r_peak       (r_peak),
        .rr_valid     (rr_valid),
        .rr_interval  (rr_interval),
        .beat_accepted(beat_accepted),
        .dec_valid    (dec_valid),
        .dec_value    (dec_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Detector model state
    bit          m_small;
    logic [7:0]  m_dec_len;
    longint      m_base, m_short, m_long;
    longint      m_rise_avg, m_fall_avg, m_rise_pk, m_fall_pk, m_rise_lvl, m_fall_lvl;
    longint      m_rise_raw, m_fall_raw;
    longint      m_rise_age, m_fall_age, m_since_beat;
    logic [31:0] m_rise_ms, m_fall_ms, m_beat_ms, m_prior_ms;
    logic [7:0]  m_dec_cnt;
    longint      m_dec_sum;

    beat_word_t  expected_words[$];
    int          err_count;
    longint      cycle_count = 0;
    bit          quiet_mode;

    // Q16 helpers: rounding is add half then floor
    function automatic longint rnd16(longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic longint ema(longint y, longint x, longint k);
        return y + rnd16((x - y) * k);
    endfunction

    function automatic longint age_inc(longint a);
        return (a >= AGE_TOP) ? AGE_TOP : a + 1;
    endfunction

    // Threshold factor from position within the expected RR interval
    function automatic longint rr_fit(logic [31:0] now);
        logic [31:0] dtw, rrw;
        longint      dt, den, e, dd, cap;
        cap = m_small ? 65536 : 85197;
        dtw = now - m_beat_ms;
        rrw = m_beat_ms - m_prior_ms;
        dt  = longint'(dtw);
        den = longint'(rrw) + 1;
        if (dt >= 2 * den)
            return cap;
        e  = ((dt << 16) / den) - 65536;
        dd = 39322 + ((10 * e * e + 32768) >> 16);
        return (dd > cap) ? cap : dd;
    endfunction

    function automatic void detector_reset();
        m_small = 0;
        m_dec_len = ecgr_pkg::DEC_LEN_RESET;
        m_base = 0; m_short = 0; m_long = 0;
        m_rise_avg = 0; m_fall_avg = 0; m_rise_pk = 0; m_fall_pk = 0;
        m_rise_lvl = 0; m_fall_lvl = 0; m_rise_raw = 0; m_fall_raw = 0;
        m_rise_age = 0; m_fall_age = 0; m_since_beat = 0;
        m_rise_ms = 0; m_fall_ms = 0; m_beat_ms = 0; m_prior_ms = 0;
        m_dec_cnt = 0; m_dec_sum = 0;
    endfunction

    // One sample through the detector; returns the output word it causes
    function automatic beat_word_t detect_beat(logic signed [SW-1:0] smp, logic [31:0] now);
        beat_word_t  w;
        longint      x, xq, v, dv, kd, fit, fit_r, fit_f, pair, len, val;
        logic [31:0] win, refr, rr;
        w = '0;
        x = longint'(smp);
        xq = x * 128;
        m_base  = ema(m_base, xq, m_small ? 1311 : 655);
        v = xq - m_base;
        m_short = ema(m_short, v, m_small ? 19661 : 13107);
        m_long  = ema(m_long, v, m_small ? 9830 : 6554);
        dv = m_short - m_long;
        m_rise_avg = ema(m_rise_avg, (dv > 0) ? dv : 0, m_small ? 13107 : 6554);
        m_fall_avg = ema(m_fall_avg, (dv < 0) ? -dv : 0, m_small ? 13107 : 6554);
        kd = m_small ? 65339 : 65484;
        m_rise_pk = rnd16(m_rise_pk * kd);
        m_fall_pk = rnd16(m_fall_pk * kd);

        fit   = rr_fit(now);
        win   = m_small ? 32'd30 : 32'd100;
        fit_r = ((now - m_rise_ms) < win) ? 66191 : fit;
        fit_f = ((now - m_fall_ms) < win) ? 66191 : fit;
        pair  = m_small ? 20 : 40;

        // rise side first; the fall side then sees a fresh rise age
        if ((m_rise_avg << 16) > m_rise_pk * fit_r) begin
            m_rise_ms = now;
            m_rise_age = 0;
            m_rise_pk = m_rise_avg;
            m_rise_lvl = m_rise_avg;
            m_rise_raw = x;
            if (m_fall_age < pair && 3 * m_rise_lvl > m_fall_lvl
                    && m_rise_lvl < 3 * m_fall_lvl) begin
                w.r_det = 1;
                m_since_beat = 0;
            end
        end
        if ((m_fall_avg << 16) > m_fall_pk * fit_f) begin
            m_fall_ms = now;
            m_fall_age = 0;
            m_fall_pk = m_fall_avg;
            m_fall_lvl = m_fall_avg;
            m_fall_raw = x;
            if (m_rise_age < pair && 3 * m_rise_lvl > m_fall_lvl
                    && m_rise_lvl < 3 * m_fall_lvl) begin
                w.r_det = 1;
                m_since_beat = 0;
            end
        end

        // delayed acceptance and RR report
        if (m_since_beat == 30) begin
            refr = m_small ? 32'd60 : 32'd150;
            if ((now - m_beat_ms) > refr) begin
                m_prior_ms = m_beat_ms;
                m_beat_ms = now;
                w.accepted = 1;
                rr = m_beat_ms - m_prior_ms;
                if (rr < 32'd2000) begin
                    w.rr_ok = 1;
                    w.rr_ms = rr[10:0];
                end
            end
        end

        m_rise_age = age_inc(m_rise_age);
        m_fall_age = age_inc(m_fall_age);
        m_since_beat = age_inc(m_since_beat);

        // decimation with peak substitution
        len = (m_dec_len == 0) ? 1 : longint'(m_dec_len);
        m_dec_cnt = m_dec_cnt + 8'd1;
        m_dec_sum += x;
        if (longint'(m_dec_cnt) >= len) begin
            val = m_dec_sum / len;
            m_dec_cnt = 0;
            m_dec_sum = 0;
            if (m_fall_age <= len) val = m_fall_raw;
            if (m_rise_age <= len) val = m_rise_raw;
            w.d_ok = 1;
            w.d_val = val[SW-1:0];
        end
        return w;
    endfunction

    function automatic int idle_draw();
        if (quiet_mode || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Clock and cycle limit
    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side: random stall, then compare the accepted word
    initial begin : out_side
        beat_word_t got, want;
        int         n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            n = idle_draw();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got = '{r_peak, rr_valid, rr_interval, beat_accepted, dec_valid, dec_value};
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word %p", $time, got);
                err_count++;
            end else begin
                want = expected_words.pop_front();
                if (got.r_det !== want.r_det)
                    $display("%0t: r_peak exp %0d got %0d", $time, want.r_det, got.r_det);
                if (got.rr_ok !== want.rr_ok)
                    $display("%0t: rr_valid exp %0d got %0d", $time, want.rr_ok, got.rr_ok);
                if (got.rr_ms !== want.rr_ms)
                    $display("%0t: rr_interval exp %0d got %0d", $time, want.rr_ms, got.rr_ms);
                if (got.accepted !== want.accepted)
                    $display("%0t: beat_accepted exp %0d got %0d", $time,
                             want.accepted, got.accepted);
                if (got.d_ok !== want.d_ok)
                    $display("%0t: dec_valid exp %0d got %0d", $time, want.d_ok, got.d_ok);
                if (got.d_val !== want.d_val)
                    $display("%0t: dec_value exp %0d got %0d", $time, want.d_val, got.d_val);
                if (got !== want)
                    err_count++;
            end
        end
    end

    // Send one word; typed rows carry their own expected word
    task automatic send_sample(logic signed [SW-1:0] smp, logic [31:0] t,
                               bit typed = 0, beat_word_t want = '0);
        beat_word_t w;
        int         n;
        n = idle_draw();
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= smp;
        time_ms  <= t;
        do @(posedge clk); while (in_stall);
        w = detect_beat(smp, t);
        expected_words.push_back(typed ? want : w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [ecgr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == ecgr_pkg::CFG_SMALL_MODE)
            m_small = val[0];
        else if (idx == ecgr_pkg::CFG_DEC_LENGTH)
            m_dec_len = val;
    endtask

    // Heartbeat train: random baseline offset, noise, a QRS-like up/down spike
    task automatic heart_train(int count, logic [31:0] t0, output logic [31:0] t_end);
        logic [31:0] t;
        int          period, pos, step, amp, offs, k, lvl;
        t = t0;
        period = $urandom_range(40, 160);
        pos = $urandom_range(0, period - 1);
        step = $urandom_range(1, 5);
        amp = $urandom_range(20000, 3000000);
        offs = $urandom_range(0, 4000000) - 2000000;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                // noise word or time jump
                if ($urandom_range(0, 1))
                    send_sample(SW'($urandom), t);
                else begin
                    t += $urandom_range(0, 3000);
                    send_sample(SW'(offs), t);
                end
            end else begin
                lvl = offs + $urandom_range(0, 2000) - 1000;
                if (pos < 4)
                    lvl += amp * (pos + 1) / 4;
                else if (pos < 8)
                    lvl += amp * (7 - pos) / 4 - amp / 3;
                if (lvl > 8388607) lvl = 8388607;
                if (lvl < -8388608) lvl = -8388608;
                send_sample(SW'(lvl), t);
            end
            t += step;
            pos++;
            if (pos >= period) begin
                pos = 0;
                if ($urandom_range(0, 4) == 0)
                    period = $urandom_range(30, 300);
            end
        end
        t_end = t;
    endtask

    // Main sequence
    initial begin : main_seq
        stim_row_t   rows[$];
        logic [31:0] t;
        int          p;
        err_count   = 0;
        quiet_mode  = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        sample    <= '0;
        time_ms   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        detector_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: quiet input after reset is all zero
        rows.push_back('{0, 0, 1, '0});
        rows.push_back('{0, 1, 1, '0});
        rows.push_back('{0, 2, 1, '0});
        rows.push_back('{24'sh7FFFFF, 3, 0, '0});
        rows.push_back('{24'sh7FFFFF, 4, 0, '0});
        rows.push_back('{-24'sh800000, 5, 0, '0});
        rows.push_back('{-24'sh800000, 6, 0, '0});
        rows.push_back('{24'sh7FFFFF, 7, 0, '0});
        rows.push_back('{24'shAAAAAA, 32'hAAAAAAAA, 0, '0});
        rows.push_back('{24'sh555555, 32'h55555555, 0, '0});
        rows.push_back('{-1, 32'hFFFFFFFE, 0, '0});
        rows.push_back('{-24'sh800000, 32'hFFFFFFFF, 0, '0});
        rows.push_back('{24'sh7FFFFF, 0, 0, '0});
        rows.push_back('{1, 1, 0, '0});
        rows.push_back('{0, 400, 0, '0});
        rows.push_back('{24'sh400000, 401, 0, '0});
        rows.push_back('{-24'sh400000, 402, 0, '0});
        rows.push_back('{0, 403, 0, '0});
        foreach (rows[i])
            send_sample(rows[i].smp, rows[i].t, rows[i].typed, rows[i].want);
        wait_drained();

        // register phases, extremes included; spare index must be ignored
        t = 500;
        for (p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    write_reg(ecgr_pkg::CFG_SMALL_MODE, 8'd0);
                    write_reg(ecgr_pkg::CFG_DEC_LENGTH, 8'd1);
                end
                1: begin
                    write_reg(ecgr_pkg::CFG_SMALL_MODE, 8'd1);
                    write_reg(ecgr_pkg::CFG_DEC_LENGTH, 8'd255);
                end
                2: begin
                    write_reg(ecgr_pkg::CFG_SMALL_MODE, 8'hFE);
                    write_reg(ecgr_pkg::CFG_DEC_LENGTH, 8'd0);
                end
                3: begin
                    write_reg(ecgr_pkg::CFG_SMALL_MODE, 8'hFF);
                    write_reg(ecgr_pkg::CFG_DEC_LENGTH, 8'd5);
                    write_reg(CFG_IDX_SPARE, 8'd0);
                end
                4: begin
                    write_reg(ecgr_pkg::CFG_SMALL_MODE, 8'd0);
                    write_reg(ecgr_pkg::CFG_DEC_LENGTH, 8'd8);
                    write_reg(CFG_IDX_SPARE, 8'hFF);
                end
                default: begin
                    write_reg(ecgr_pkg::CFG_DEC_LENGTH, 8'd16);
                end
            endcase
            quiet_mode = (p == 4);
            heart_train(150, t, t);
            // hold off until all pending words are back
            wait_drained();
            heart_train(150, t, t);
            wait_drained();
        end

        // end of run
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
